// ----- src/zoned_page_frame_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the top level.
`ifndef ZONED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define ZONED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define ZPFA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked during reset as well.
`define ZPFA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/zpfa_pkg.sv -----
// Types and constants of the zoned page frame allocator.
// Depends on nothing; used by every module of the block.
package zpfa_pkg;

   localparam int PAGES      = 65536;
   localparam int PAGE_SHIFT = 12;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(PAGES);
   localparam int LINK_BITS  = IDX_BITS + 1;
   localparam int REG_BITS   = 17;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(PAGES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [REG_BITS-1:0] RESET_PAGE_LIMIT = REG_BITS'(PAGES);
   localparam logic [REG_BITS-1:0] RESET_BIOS_PAGES = REG_BITS'(32'h100000 >> PAGE_SHIFT);
   localparam logic [REG_BITS-1:0] RESET_ISA_PAGES  = REG_BITS'(32'h1000000 >> PAGE_SHIFT);

   localparam logic [CSR_IDX_BITS-1:0] CSR_PAGE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BIOS_PAGES = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ISA_PAGES  = 2'd2;

   localparam logic [2:0] ACT_ALLOC     = 3'd0;
   localparam logic [2:0] ACT_FREE      = 3'd1;
   localparam logic [2:0] ACT_REFERENCE = 3'd2;
   localparam logic [2:0] ACT_RESERVE   = 3'd3;
   localparam logic [2:0] ACT_UNRESERVE = 3'd4;
   localparam logic [2:0] ACT_READ      = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_NO_PAGE   = 3'd2;
   localparam logic [2:0] ST_FREE      = 3'd3;
   localparam logic [2:0] ST_RESERVED  = 3'd4;
   localparam logic [2:0] ST_IN_USE    = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;

   localparam logic [1:0] ZONE_BIOS   = 2'd0;
   localparam logic [1:0] ZONE_ISA    = 2'd1;
   localparam logic [1:0] ZONE_NORMAL = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] address;
      logic        want_isa;
      logic        want_bios;
      logic        want_clear;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [31:0]           page_address;
      logic [COUNT_BITS-1:0] ref_count;
      logic                  clear_needed;
   } rsp_type;

   // One entry of the page memory: count, reserved mark and both links.
   typedef struct packed {
      logic [COUNT_BITS-1:0] refs;
      logic                  reserved;
      logic [LINK_BITS-1:0]  next;
      logic [LINK_BITS-1:0]  prev;
   } page_entry_type;

endpackage

// ----- src/zpfa_page_ram.sv -----
// Single-port page memory with registered read.
// Depends on zpfa_pkg for the entry type and depth.
module zpfa_page_ram (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [zpfa_pkg::IDX_BITS-1:0]         addr,
   input  zpfa_pkg::page_entry_type              wr_data,
   output zpfa_pkg::page_entry_type              rd_data
);

   zpfa_pkg::page_entry_type mem [zpfa_pkg::PAGES];

   // Write or read one entry per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

// ----- src/zoned_page_frame_allocator.sv -----
// Usage notes:
// Requests arrive on req_valid/req_ready with a req_type payload; one
// response per request leaves on rsp_valid/rsp_ready as an rsp_type.
// The csr_ port writes page_limit (0), bios_zone_pages (1) and
// isa_zone_pages (2); the user must write them only while the block is
// idle, as the block itself does not enforce it. One request is worked at
// a time through a sequencer around a single page memory (count, reserved
// mark, next and prev links per page). Each memory access is a read then a
// write. A rejected action or an alloc with no free page ends after the
// page selection; a read or an error found in the page entry ends after the
// entry read; a change writes its own entry, then reads and writes each
// neighbor that needs a fixup: one for a push or an alloc of a page with a
// successor, two for a reserve that unlinks a page with both neighbors. The
// sequencer then returns to idle. The page memory port sets the rate.
// The response sits in an output register; the next request is accepted
// while it waits, and the sequencer stalls only when it has a new
// response and the register is still full.
// Reset clears the registers and zone heads, then the sequencer sweeps all
// PAGES entries, one a cycle, to zero counts and set reserved marks; no
// request is accepted until the sweep ends.
`include "zoned_page_frame_allocator_defines.svh"
module zoned_page_frame_allocator (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  zpfa_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output zpfa_pkg::rsp_type                        rsp_data,
   input  logic                                     csr_write,
   input  logic [zpfa_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [zpfa_pkg::REG_BITS-1:0]            csr_wdata
);

   localparam int IB = zpfa_pkg::IDX_BITS;
   localparam int LB = zpfa_pkg::LINK_BITS;
   localparam int CB = zpfa_pkg::COUNT_BITS;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_MAIN, S_EVAL, S_RD_A, S_MOD_A, S_RD_B, S_MOD_B,
      S_WR_MAIN, S_DONE
   } state_type;

   state_type state_ff;
   logic [zpfa_pkg::REG_BITS-1:0] limit_ff, bios_ff, isa_ff;
   logic [LB-1:0] head_ff [3];
   logic [IB-1:0] clr_ff;
   zpfa_pkg::req_type req_ff;
   zpfa_pkg::page_entry_type ent_ff;
   logic [IB-1:0] idx_ff;
   logic [2:0] st_ff;
   // Neighbor fixups: A writes one link of entry a, B one of entry b.
   logic a_do_ff, b_do_ff;
   logic [IB-1:0] a_idx_ff, b_idx_ff;
   logic [LB-1:0] a_val_ff, b_val_ff;
   logic a_is_next_ff;
   logic rsp_valid_ff;
   zpfa_pkg::rsp_type rsp_ff;

   logic ram_we;
   logic [IB-1:0] ram_addr;
   zpfa_pkg::page_entry_type ram_wd, ram_rd;

   zpfa_page_ram u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Page index and range check of the held request.
   logic [31-zpfa_pkg::PAGE_SHIFT:0] req_idx_full;
   logic in_range;
   assign req_idx_full = req_ff.address[31:zpfa_pkg::PAGE_SHIFT];
   assign in_range = (33'(req_idx_full) < 33'(limit_ff))
                  && (33'(req_idx_full) < 33'(zpfa_pkg::PAGES));

   // Alloc zone choice.
   logic [1:0] alloc_zone;
   always_comb begin
      alloc_zone = zpfa_pkg::ZONE_NORMAL;
      if (req_ff.want_isa || head_ff[zpfa_pkg::ZONE_NORMAL] == zpfa_pkg::NIL) begin
         alloc_zone = zpfa_pkg::ZONE_ISA;
      end
      if (req_ff.want_bios || head_ff[alloc_zone] == zpfa_pkg::NIL) begin
         alloc_zone = zpfa_pkg::ZONE_BIOS;
      end
   end

   // Zone of the page being pushed.
   logic [1:0] push_zone;
   always_comb begin
      if (17'(idx_ff) < bios_ff) begin
         push_zone = zpfa_pkg::ZONE_BIOS;
      end else if (17'(idx_ff) < isa_ff) begin
         push_zone = zpfa_pkg::ZONE_ISA;
      end else begin
         push_zone = zpfa_pkg::ZONE_NORMAL;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Memory port control.
   always_comb begin
      ram_we = 1'b0;
      ram_addr = idx_ff;
      ram_wd = ent_ff;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            ram_wd = '{refs: '0, reserved: 1'b1, next: zpfa_pkg::NIL, prev: zpfa_pkg::NIL};
         end
         S_RD_MAIN: begin
            // Launch the read of the selected page so it is ready in S_EVAL.
            if (req_ff.action == zpfa_pkg::ACT_ALLOC) begin
               ram_addr = head_ff[alloc_zone][IB-1:0];
            end else begin
               ram_addr = req_idx_full[IB-1:0];
            end
         end
         S_RD_A:  ram_addr = a_idx_ff;
         S_MOD_A: begin
            ram_we = 1'b1;
            ram_addr = a_idx_ff;
            ram_wd = ram_rd;
            if (a_is_next_ff) begin
               ram_wd.next = a_val_ff;
            end else begin
               ram_wd.prev = a_val_ff;
            end
         end
         S_RD_B:  ram_addr = b_idx_ff;
         S_MOD_B: begin
            ram_we = 1'b1;
            ram_addr = b_idx_ff;
            ram_wd = ram_rd;
            ram_wd.prev = b_val_ff;
         end
         S_WR_MAIN: ram_we = 1'b1;
         default: ram_addr = idx_ff;
      endcase
   end

   // Sequencer, registers and response.
   always_ff @(posedge clock) begin
      zpfa_pkg::page_entry_type ent_v;
      zpfa_pkg::rsp_type rsp_v;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         limit_ff <= zpfa_pkg::RESET_PAGE_LIMIT;
         bios_ff <= zpfa_pkg::RESET_BIOS_PAGES;
         isa_ff <= zpfa_pkg::RESET_ISA_PAGES;
         for (int z = 0; z < 3; z++) begin
            head_ff[z] <= zpfa_pkg::NIL;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               zpfa_pkg::CSR_PAGE_LIMIT: limit_ff <= csr_wdata;
               zpfa_pkg::CSR_BIOS_PAGES: bios_ff <= csr_wdata;
               zpfa_pkg::CSR_ISA_PAGES:  isa_ff <= csr_wdata;
               default: ;
            endcase
         end
         // A taken response empties the register unless a new one replaces it.
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IB'(zpfa_pkg::PAGES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  a_do_ff <= 1'b0;
                  b_do_ff <= 1'b0;
                  st_ff <= zpfa_pkg::ST_OK;
                  state_ff <= S_RD_MAIN;
               end
            end
            S_RD_MAIN: begin
               // Select the page and launch its read.
               if (req_ff.action == zpfa_pkg::ACT_ALLOC) begin
                  if (head_ff[alloc_zone] == zpfa_pkg::NIL) begin
                     st_ff <= zpfa_pkg::ST_NO_PAGE;
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff <= head_ff[alloc_zone][IB-1:0];
                     state_ff <= S_EVAL;
                  end
               end else if (req_ff.action > zpfa_pkg::ACT_READ || !in_range) begin
                  st_ff <= zpfa_pkg::ST_RANGE;
                  state_ff <= S_DONE;
               end else begin
                  idx_ff <= req_idx_full[IB-1:0];
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               ent_v = ram_rd;
               case (req_ff.action)
                  zpfa_pkg::ACT_ALLOC: begin
                     // Unlink the head: its prev is NIL.
                     for (int z = 0; z < 3; z++) begin
                        if (head_ff[z] == {1'b0, idx_ff}) head_ff[z] <= ram_rd.next;
                     end
                     ent_v.refs = CB'(1);
                     b_do_ff <= (ram_rd.next != zpfa_pkg::NIL);
                     b_idx_ff <= ram_rd.next[IB-1:0];
                     b_val_ff <= ram_rd.prev;
                     state_ff <= S_WR_MAIN;
                  end
                  zpfa_pkg::ACT_FREE: begin
                     if (ram_rd.refs == '0) begin
                        st_ff <= zpfa_pkg::ST_FREE;
                        state_ff <= S_DONE;
                     end else if (ram_rd.reserved) begin
                        st_ff <= zpfa_pkg::ST_RESERVED;
                        state_ff <= S_DONE;
                     end else begin
                        ent_v.refs = ram_rd.refs - 1'b1;
                        if (ram_rd.refs == CB'(1)) begin
                           ent_v.next = head_ff[push_zone];
                           ent_v.prev = zpfa_pkg::NIL;
                           head_ff[push_zone] <= {1'b0, idx_ff};
                           b_do_ff <= (head_ff[push_zone] != zpfa_pkg::NIL);
                           b_idx_ff <= head_ff[push_zone][IB-1:0];
                           b_val_ff <= {1'b0, idx_ff};
                        end
                        state_ff <= S_WR_MAIN;
                     end
                  end
                  zpfa_pkg::ACT_REFERENCE: begin
                     if (ram_rd.reserved) begin
                        st_ff <= zpfa_pkg::ST_RESERVED;
                        state_ff <= S_DONE;
                     end else if (ram_rd.refs == '0) begin
                        st_ff <= zpfa_pkg::ST_FREE;
                        state_ff <= S_DONE;
                     end else if (ram_rd.refs == zpfa_pkg::COUNT_MAX) begin
                        st_ff <= zpfa_pkg::ST_OVERFLOW;
                        state_ff <= S_DONE;
                     end else begin
                        ent_v.refs = ram_rd.refs + 1'b1;
                        state_ff <= S_WR_MAIN;
                     end
                  end
                  zpfa_pkg::ACT_RESERVE: begin
                     if (ram_rd.refs != '0) begin
                        st_ff <= zpfa_pkg::ST_IN_USE;
                        state_ff <= S_DONE;
                     end else if (ram_rd.reserved) begin
                        state_ff <= S_DONE;
                     end else begin
                        ent_v.reserved = 1'b1;
                        if (ram_rd.prev == zpfa_pkg::NIL) begin
                           for (int z = 0; z < 3; z++) begin
                              if (head_ff[z] == {1'b0, idx_ff}) head_ff[z] <= ram_rd.next;
                           end
                        end
                        a_do_ff <= (ram_rd.prev != zpfa_pkg::NIL);
                        a_idx_ff <= ram_rd.prev[IB-1:0];
                        a_val_ff <= ram_rd.next;
                        a_is_next_ff <= 1'b1;
                        b_do_ff <= (ram_rd.next != zpfa_pkg::NIL);
                        b_idx_ff <= ram_rd.next[IB-1:0];
                        b_val_ff <= ram_rd.prev;
                        state_ff <= S_WR_MAIN;
                     end
                  end
                  zpfa_pkg::ACT_UNRESERVE: begin
                     if (!ram_rd.reserved) begin
                        st_ff <= zpfa_pkg::ST_OVERFLOW;
                        state_ff <= S_DONE;
                     end else begin
                        ent_v.reserved = 1'b0;
                        if (ram_rd.refs == '0) begin
                           ent_v.next = head_ff[push_zone];
                           ent_v.prev = zpfa_pkg::NIL;
                           head_ff[push_zone] <= {1'b0, idx_ff};
                           b_do_ff <= (head_ff[push_zone] != zpfa_pkg::NIL);
                           b_idx_ff <= head_ff[push_zone][IB-1:0];
                           b_val_ff <= {1'b0, idx_ff};
                        end
                        state_ff <= S_WR_MAIN;
                     end
                  end
                  default: begin
                     if (ram_rd.reserved) st_ff <= zpfa_pkg::ST_RESERVED;
                     state_ff <= S_DONE;
                  end
               endcase
               ent_ff <= ent_v;
            end
            S_WR_MAIN: begin
               // Own entry written; then neighbor fixups.
               if (a_do_ff) begin
                  state_ff <= S_RD_A;
               end else if (b_do_ff) begin
                  state_ff <= S_RD_B;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_RD_A: state_ff <= S_MOD_A;
            S_MOD_A: state_ff <= b_do_ff ? S_RD_B : S_DONE;
            S_RD_B: state_ff <= S_MOD_B;
            S_MOD_B: state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_v = '0;
                  rsp_v.status = st_ff;
                  if (req_ff.action == zpfa_pkg::ACT_ALLOC) begin
                     if (st_ff == zpfa_pkg::ST_OK) begin
                        rsp_v.page_address = 32'({idx_ff, zpfa_pkg::PAGE_SHIFT'(0)});
                        rsp_v.ref_count = CB'(1);
                        rsp_v.clear_needed = req_ff.want_clear;
                     end
                  end else if (st_ff != zpfa_pkg::ST_RANGE) begin
                     rsp_v.ref_count = ent_ff.refs;
                     if (st_ff == zpfa_pkg::ST_OK) begin
                        rsp_v.page_address = {req_ff.address[31:zpfa_pkg::PAGE_SHIFT],
                                              zpfa_pkg::PAGE_SHIFT'(0)};
                     end
                  end
                  rsp_ff <= rsp_v;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Error paths load the count from memory too; capture it on exit.
   // (Error exits from S_EVAL go straight to S_DONE with ent_ff loaded.)

   // Checks on the sequencer.
   `ZPFA_ASSERT(a_no_accept_clear, clock, reset,
                state_ff == S_CLEAR |-> !req_ready,
                "request accepted during clearing pass")
   `ZPFA_ASSERT(a_rsp_hold, clock, reset,
                (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data),
                "stalled response changed")
   `ZPFA_ASSERT(a_alloc_count, clock, reset,
                (rsp_valid && rsp_data.status == zpfa_pkg::ST_NO_PAGE) |-> rsp_data.ref_count == '0,
                "failed alloc reports a count")
   `ZPFA_ASSERT_ALWAYS(a_reset_idle_rsp, clock,
                       $past(reset) |-> !rsp_valid,
                       "response valid after reset")

endmodule
